// ===== hdl/icr_pkg.sv =====
`timescale 1ns / 1ps

package icr_pkg;

    localparam int DIGITAL_PINS_DEF = 30;
    localparam int ANALOG_PINS_DEF  = 5;

    localparam int OP_W     = 3;
    localparam int PIN_W    = 5;
    localparam int MODE_W   = 3;
    localparam int SUB_W    = 3;
    localparam int THR_W    = 16;
    localparam int SAMPLE_W = 12;

    localparam logic [OP_W-1:0] OP_SET_MODE = 3'd0;
    localparam logic [OP_W-1:0] OP_MODIFY   = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP     = 3'd2;
    localparam logic [OP_W-1:0] OP_RESUME   = 3'd3;
    localparam logic [OP_W-1:0] OP_DIGITAL  = 3'd4;
    localparam logic [OP_W-1:0] OP_ANALOG   = 3'd5;

    localparam logic [MODE_W-1:0] MODE_INPUT     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_OUTPUT    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PWM       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PULL_UP   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PULL_DOWN = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ANALOG    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_NOT_SET   = 3'd7;

    localparam logic [SUB_W-1:0] SUB_DISABLE_ALL = 3'd0;
    localparam logic [SUB_W-1:0] SUB_ANALOG_EN   = 3'd1;
    localparam logic [SUB_W-1:0] SUB_DIGITAL_EN  = 3'd2;
    localparam logic [SUB_W-1:0] SUB_ANALOG_DIS  = 3'd3;
    localparam logic [SUB_W-1:0] SUB_DIGITAL_DIS = 3'd4;

    localparam logic KIND_DIGITAL = 1'b0;
    localparam logic KIND_ANALOG  = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              last;
    } t_dig_entry;

    typedef struct packed {
        logic [SAMPLE_W-1:0] last;
        logic [THR_W-1:0]    thr;
    } t_ana_entry;

    function automatic logic is_input_mode(input logic [MODE_W-1:0] m);
        return (m == MODE_INPUT) || (m == MODE_PULL_UP) || (m == MODE_PULL_DOWN);
    endfunction

endpackage

// ===== hdl/input_change_reporter_core.sv =====
`timescale 1ns / 1ps

// a reported item reaches o_valid through the execute stage and output registers
// throughput: one item per cycle unless the output stalls; the pin tables are read at
// accept and written back at execute, forwarded when back-to-back items hit one entry
// reset: synchronous, active low; pipeline and output empty, reports running,
// every pin entry reads as its reset value through per-entry valid bits, no clearing pass
module input_change_reporter_core #(
    parameter int DIGITAL_PINS = icr_pkg::DIGITAL_PINS_DEF,
    parameter int ANALOG_PINS  = icr_pkg::ANALOG_PINS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [icr_pkg::OP_W-1:0]      i_op,
    input  logic [icr_pkg::PIN_W-1:0]     i_pin,
    input  logic [icr_pkg::MODE_W-1:0]    i_mode,
    input  logic [icr_pkg::SUB_W-1:0]     i_sub_command,
    input  logic                          i_enable_flag,
    input  logic [icr_pkg::THR_W-1:0]     i_threshold,
    input  logic                          i_level,
    input  logic [icr_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_report_kind,
    output logic [icr_pkg::PIN_W-1:0]     o_report_pin,
    output logic [icr_pkg::SAMPLE_W-1:0]  o_report_value
);
    import icr_pkg::*;

    localparam int DA = (DIGITAL_PINS > 1) ? $clog2(DIGITAL_PINS) : 1;
    localparam int AA = (ANALOG_PINS > 1) ? $clog2(ANALOG_PINS) : 1;

    // pin tables
    t_dig_entry r_dmem [DIGITAL_PINS];
    t_ana_entry r_amem [ANALOG_PINS];

    logic [DIGITAL_PINS-1:0] r_d_vld, n_d_vld;
    logic [DIGITAL_PINS-1:0] r_d_en, n_d_en;
    logic [ANALOG_PINS-1:0]  r_a_vld, n_a_vld;
    logic [ANALOG_PINS-1:0]  r_a_en, n_a_en;
    logic                    r_stop, n_stop;

    // execute stage
    logic                r_s1_vld;
    logic [OP_W-1:0]     r_op;
    logic [PIN_W-1:0]    r_pin;
    logic [MODE_W-1:0]   r_mode;
    logic [SUB_W-1:0]    r_sub;
    logic                r_en;
    logic [THR_W-1:0]    r_thr;
    logic                r_level;
    logic [SAMPLE_W-1:0] r_sample;
    t_dig_entry          r_drd, r_dfwd;
    t_ana_entry          r_ard, r_afwd;
    logic                r_dfwd_hit, r_afwd_hit;

    // output register
    logic                r_o_vld;
    logic                r_o_kind;
    logic [PIN_W-1:0]    r_o_pin;
    logic [SAMPLE_W-1:0] r_o_value;

    logic                in_acc, s1_fire;
    logic                d_in_rng, a_in_rng;
    logic [DA-1:0]       d_idx;
    logic [AA-1:0]       a_idx;
    t_dig_entry          d_cur, d_wr_data;
    t_ana_entry          a_cur, a_wr_data;
    logic                d_wr, a_wr;
    logic                rep;
    logic                rep_kind;
    logic [SAMPLE_W-1:0] rep_value;
    logic [SAMPLE_W-1:0] a_diff;

    assign s1_fire = r_s1_vld && (!r_o_vld || !i_stall);
    assign o_stall = r_s1_vld && !s1_fire;
    assign in_acc  = i_valid && !o_stall;

    assign d_idx    = r_pin[DA-1:0];
    assign a_idx    = r_pin[AA-1:0];
    assign d_in_rng = {1'b0, r_pin} < (PIN_W+1)'(DIGITAL_PINS);
    assign a_in_rng = {1'b0, r_pin} < (PIN_W+1)'(ANALOG_PINS);

    always_comb begin
        if (r_dfwd_hit) begin
            d_cur = r_dfwd;
        end else if (d_in_rng && r_d_vld[d_idx]) begin
            d_cur = r_drd;
        end else begin
            d_cur = '{mode: MODE_NOT_SET, last: 1'b0};
        end
        if (r_afwd_hit) begin
            a_cur = r_afwd;
        end else if (a_in_rng && r_a_vld[a_idx]) begin
            a_cur = r_ard;
        end else begin
            a_cur = '0;
        end
    end

    assign a_diff = (r_sample >= a_cur.last) ? (r_sample - a_cur.last)
                                             : (a_cur.last - r_sample);

    always_comb begin
        n_d_en    = r_d_en;
        n_a_en    = r_a_en;
        n_d_vld   = r_d_vld;
        n_a_vld   = r_a_vld;
        n_stop    = r_stop;
        d_wr      = 1'b0;
        a_wr      = 1'b0;
        d_wr_data = d_cur;
        a_wr_data = a_cur;
        rep       = 1'b0;
        rep_kind  = KIND_DIGITAL;
        rep_value = '0;
        if (s1_fire) begin
            unique case (r_op)
                OP_SET_MODE: begin
                    if (r_mode == MODE_ANALOG) begin
                        if (a_in_rng) begin
                            n_a_en[a_idx] = r_en;
                            a_wr          = 1'b1;
                            a_wr_data.thr = r_thr;
                        end
                    end else if (d_in_rng) begin
                        if (is_input_mode(r_mode)) begin
                            n_d_en[d_idx]  = r_en;
                            d_wr           = 1'b1;
                            d_wr_data.mode = r_mode;
                        end else if (r_mode == MODE_OUTPUT || r_mode == MODE_PWM) begin
                            d_wr           = 1'b1;
                            d_wr_data.mode = r_mode;
                        end
                    end
                end
                OP_MODIFY: begin
                    unique case (r_sub)
                        SUB_DISABLE_ALL: begin
                            n_d_en = '0;
                            n_a_en = '0;
                        end
                        SUB_ANALOG_EN, SUB_ANALOG_DIS: begin
                            if (a_in_rng) begin
                                n_a_en[a_idx] = (r_sub == SUB_ANALOG_EN);
                            end
                        end
                        SUB_DIGITAL_EN, SUB_DIGITAL_DIS: begin
                            if (d_in_rng && d_cur.mode != MODE_NOT_SET) begin
                                n_d_en[d_idx] = (r_sub == SUB_DIGITAL_EN);
                            end
                        end
                        default: ;
                    endcase
                end
                OP_STOP:   n_stop = 1'b1;
                OP_RESUME: n_stop = 1'b0;
                OP_DIGITAL: begin
                    if (!r_stop && d_in_rng && is_input_mode(d_cur.mode) && r_d_en[d_idx]
                        && r_level != d_cur.last) begin
                        d_wr           = 1'b1;
                        d_wr_data.last = r_level;
                        rep            = 1'b1;
                        rep_kind       = KIND_DIGITAL;
                        rep_value      = {{(SAMPLE_W-1){1'b0}}, r_level};
                    end
                end
                OP_ANALOG: begin
                    if (!r_stop && a_in_rng && r_a_en[a_idx]
                        && {{(THR_W-SAMPLE_W){1'b0}}, a_diff} >= a_cur.thr) begin
                        a_wr           = 1'b1;
                        a_wr_data.last = r_sample;
                        rep            = 1'b1;
                        rep_kind       = KIND_ANALOG;
                        rep_value      = r_sample;
                    end
                end
                default: ;
            endcase
            if (d_wr) begin
                n_d_vld[d_idx] = 1'b1;
            end
            if (a_wr) begin
                n_a_vld[a_idx] = 1'b1;
            end
        end
    end

    // table memories, read at accept and written back from the execute stage
    always_ff @(posedge i_clk) begin
        if (d_wr) begin
            r_dmem[d_idx] <= d_wr_data;
        end
        if (a_wr) begin
            r_amem[a_idx] <= a_wr_data;
        end
        if (in_acc) begin
            r_drd <= r_dmem[i_pin[DA-1:0]];
            r_ard <= r_amem[i_pin[AA-1:0]];
        end
    end

    // capture the input item and the write on the same edge as the read; register the report
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op       <= i_op;
            r_pin      <= i_pin;
            r_mode     <= i_mode;
            r_sub      <= i_sub_command;
            r_en       <= i_enable_flag;
            r_thr      <= i_threshold;
            r_level    <= i_level;
            r_sample   <= i_sample;
            r_dfwd     <= d_wr_data;
            r_afwd     <= a_wr_data;
        end
        if (s1_fire) begin
            r_o_kind  <= rep_kind;
            r_o_pin   <= r_pin;
            r_o_value <= rep_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_o_vld    <= 1'b0;
            r_d_vld    <= '0;
            r_d_en     <= '0;
            r_a_vld    <= '0;
            r_a_en     <= '0;
            r_stop     <= 1'b0;
            r_dfwd_hit <= 1'b0;
            r_afwd_hit <= 1'b0;
        end else begin
            r_d_vld <= n_d_vld;
            r_d_en  <= n_d_en;
            r_a_vld <= n_a_vld;
            r_a_en  <= n_a_en;
            r_stop  <= n_stop;
            if (in_acc) begin
                r_s1_vld   <= 1'b1;
                r_dfwd_hit <= d_wr && (d_idx == i_pin[DA-1:0]);
                r_afwd_hit <= a_wr && (a_idx == i_pin[AA-1:0]);
            end else if (s1_fire) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_fire) begin
                r_o_vld <= rep;
            end else if (!i_stall) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    assign o_valid        = r_o_vld;
    assign o_report_kind  = r_o_kind;
    assign o_report_pin   = r_o_pin;
    assign o_report_value = r_o_value;

endmodule

// ===== hdl/icr_checker.sv =====
`timescale 1ns / 1ps

module icr_checker #(
    parameter int DIGITAL_PINS = icr_pkg::DIGITAL_PINS_DEF,
    parameter int ANALOG_PINS  = icr_pkg::ANALOG_PINS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic                          o_report_kind,
    input logic [icr_pkg::PIN_W-1:0]     o_report_pin,
    input logic [icr_pkg::SAMPLE_W-1:0]  o_report_value
);
    import icr_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_report_kind)
            && $stable(o_report_pin) && $stable(o_report_value))
        else $error("stalled report beat changed");

    // input only backs up when the output register is full and held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output back-pressure");

    a_digital_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_report_kind == KIND_DIGITAL |->
            o_report_value[SAMPLE_W-1:1] == '0
            && {1'b0, o_report_pin} < (PIN_W+1)'(DIGITAL_PINS))
        else $error("bad digital report");

    a_analog_pin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_report_kind == KIND_ANALOG |->
            {1'b0, o_report_pin} < (PIN_W+1)'(ANALOG_PINS))
        else $error("analog report pin out of range");

endmodule

bind input_change_reporter_core icr_checker #(
    .DIGITAL_PINS(DIGITAL_PINS),
    .ANALOG_PINS (ANALOG_PINS)
) u_icr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_report_kind (o_report_kind),
    .o_report_pin  (o_report_pin),
    .o_report_value(o_report_value)
);
